>>> rtl/ptq_pkg.sv
package ptq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TIME_BITS   = 48;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] OP_SCHEDULE = 2'd0;
  localparam logic [1:0] OP_TICK     = 2'd1;
  localparam logic [1:0] OP_POLL     = 2'd2;

  localparam logic [1:0] KIND_ONCE  = 2'd0;
  localparam logic [1:0] KIND_RATE  = 2'd1;
  localparam logic [1:0] KIND_DELAY = 2'd2;
  localparam logic [1:0] KIND_BAD   = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  kind;
    logic [7:0]  task_id;
    logic [23:0] first_delay;
    logic [23:0] repeat_period;
  } in_word_t;

  typedef struct packed {
    logic       accepted;
    logic       fired;
    logic [7:0] fired_task;
    logic [1:0] fired_kind;
    logic [4:0] pending_count;
  } out_word_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] due;
    logic [7:0]           task_id;
    logic [1:0]           kind;
    logic [23:0]          period;
  } entry_t;

  typedef struct packed {
    logic insert;
    logic pop;
  } cell_ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_REARM
  } state_t;

endpackage

>>> rtl/periodic_task_timer_queue.sv
// result: the result word is registered in the cycle after the input word is taken
// throughput: one word per cycle while the result word is taken; a poll that re-arms a
// periodic task holds the input for the pop through the cell chain and then the sorted insert of the re-armed task
// the result register frees in the same cycle it is read, so outside a re-arm a new word may enter then
// reset (rst_n low, synchronous) empties the queue and clears the tick count;
// cell contents are left as they are

module periodic_task_timer_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ptq_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ptq_pkg::out_word_t out_data
);

  ptq_pkg::state_t state_r, state_nxt;
  logic [ptq_pkg::TIME_BITS-1:0] now_r, now_nxt;
  logic [ptq_pkg::CNT_W-1:0]     count_r, count_nxt;
  ptq_pkg::entry_t               rearm_r, rearm_nxt;
  logic                          out_valid_r, out_valid_nxt;
  ptq_pkg::out_word_t            out_data_r, out_data_nxt;

  ptq_pkg::cell_ctl_t ctl;
  ptq_pkg::entry_t    new_entry;
  ptq_pkg::entry_t    sched_entry;
  ptq_pkg::entry_t    cell_q [ptq_pkg::QUEUE_DEPTH];
  logic               keep   [ptq_pkg::QUEUE_DEPTH];
  ptq_pkg::entry_t    head;
  logic               in_fire;
  logic               head_due;
  logic               head_periodic;

  assign in_ready  = (state_r == ptq_pkg::ST_IDLE) && (!out_valid_r || out_ready);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign head          = cell_q[0];
  assign head_due      = (count_r != '0) && (head.due <= now_r);
  assign head_periodic = (head.kind == ptq_pkg::KIND_RATE) ||
                         (head.kind == ptq_pkg::KIND_DELAY);

  always_comb begin
    sched_entry.due     = now_r + ptq_pkg::TIME_BITS'(in_data.first_delay);
    sched_entry.task_id = in_data.task_id;
    sched_entry.kind    = in_data.kind;
    sched_entry.period  = in_data.repeat_period;
  end

  assign new_entry = (state_r == ptq_pkg::ST_REARM) ? rearm_r : sched_entry;

  // cell chain, slot 0 holds the earliest task
  for (genvar i = 0; i < ptq_pkg::QUEUE_DEPTH; i++) begin : g_cell
    ptq_pkg::entry_t left_e;
    ptq_pkg::entry_t right_e;
    logic            left_k;

    if (i == 0) begin : g_first
      assign left_e = new_entry;
      assign left_k = 1'b1;
    end else begin : g_rest
      assign left_e = cell_q[i-1];
      assign left_k = keep[i-1];
    end

    if (i == ptq_pkg::QUEUE_DEPTH - 1) begin : g_last
      assign right_e = cell_q[i];
    end else begin : g_inner
      assign right_e = cell_q[i+1];
    end

    ptq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .new_entry   (new_entry),
      .left_entry  (left_e),
      .right_entry (right_e),
      .left_keep   (left_k),
      .occupied    (ptq_pkg::CNT_W'(i) < count_r),
      .entry       (cell_q[i]),
      .keep        (keep[i])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ptq_pkg::ST_IDLE: begin
        if (in_fire && (in_data.op == ptq_pkg::OP_POLL) && head_due && head_periodic) begin
          state_nxt = ptq_pkg::ST_REARM;
        end
      end
      ptq_pkg::ST_REARM: begin
        state_nxt = ptq_pkg::ST_IDLE;
      end
      default: state_nxt = ptq_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    ctl           = '0;
    now_nxt       = now_r;
    count_nxt     = count_r;
    rearm_nxt     = rearm_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ptq_pkg::ST_IDLE: begin
        if (in_fire) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          case (in_data.op)
            ptq_pkg::OP_SCHEDULE: begin
              if ((in_data.kind != ptq_pkg::KIND_BAD) &&
                  (count_r < ptq_pkg::CNT_W'(ptq_pkg::QUEUE_DEPTH))) begin
                ctl.insert            = 1'b1;
                count_nxt             = count_r + 1'b1;
                out_data_nxt.accepted = 1'b1;
              end
            end
            ptq_pkg::OP_TICK: begin
              now_nxt = now_r + 1'b1;
            end
            ptq_pkg::OP_POLL: begin
              if (head_due) begin
                ctl.pop                 = 1'b1;
                count_nxt               = count_r - 1'b1;
                out_data_nxt.fired      = 1'b1;
                out_data_nxt.fired_task = head.task_id;
                out_data_nxt.fired_kind = head.kind;
                rearm_nxt               = head;
                rearm_nxt.due           = (head.kind == ptq_pkg::KIND_RATE) ?
                                          head.due + ptq_pkg::TIME_BITS'(head.period) :
                                          now_r + ptq_pkg::TIME_BITS'(head.period);
              end
            end
            default: begin
            end
          endcase
          // re-armed task is counted as soon as it is popped
          if ((in_data.op == ptq_pkg::OP_POLL) && head_due && head_periodic) begin
            out_data_nxt.pending_count = 5'(count_r);
          end else begin
            out_data_nxt.pending_count = 5'(count_nxt);
          end
        end
      end
      ptq_pkg::ST_REARM: begin
        ctl.insert = 1'b1;
        count_nxt  = count_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ptq_pkg::ST_IDLE;
      now_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      now_r       <= now_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rearm_r    <= rearm_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

>>> rtl/ptq_cell.sv
module ptq_cell (
  input  logic               clk,
  input  ptq_pkg::cell_ctl_t ctl,
  input  ptq_pkg::entry_t    new_entry,
  input  ptq_pkg::entry_t    left_entry,
  input  ptq_pkg::entry_t    right_entry,
  input  logic               left_keep,
  input  logic               occupied,
  output ptq_pkg::entry_t    entry,
  output logic               keep
);

  ptq_pkg::entry_t entry_r;
  ptq_pkg::entry_t entry_nxt;

  // entries at or before the new due time stay put, keeping equal times in arrival order
  assign keep  = occupied && (entry_r.due <= new_entry.due);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.insert) begin
      if (!keep) begin
        entry_nxt = left_keep ? new_entry : left_entry;
      end
    end else if (ctl.pop) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

>>> tb/tb_periodic_task_timer_queue.sv
module tb_periodic_task_timer_queue;

  // op code 3 has no meaning in the block
  localparam logic [1:0] OP_NONE = 2'd3;

  class timer_queue_scoreboard;
    logic [ptq_pkg::TIME_BITS-1:0] now_ticks;
    ptq_pkg::entry_t               slots[$];
    ptq_pkg::out_word_t            awaited[$];
    int                            errors;

    function new();
      now_ticks = '0;
      errors    = 0;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    // sorted insert, after every entry due at the same time
    function void file_entry(ptq_pkg::entry_t e);
      int pos;
      pos = 0;
      while (pos < slots.size() && slots[pos].due <= e.due) pos++;
      slots.insert(pos, e);
    endfunction

    function ptq_pkg::out_word_t note_word(ptq_pkg::in_word_t w);
      ptq_pkg::out_word_t r;
      ptq_pkg::entry_t    e;
      r = '0;
      case (w.op)
        ptq_pkg::OP_SCHEDULE: begin
          if (w.kind != ptq_pkg::KIND_BAD && slots.size() < ptq_pkg::QUEUE_DEPTH) begin
            e.due     = now_ticks + ptq_pkg::TIME_BITS'(w.first_delay);
            e.task_id = w.task_id;
            e.kind    = w.kind;
            e.period  = w.repeat_period;
            file_entry(e);
            r.accepted = 1'b1;
          end
        end
        ptq_pkg::OP_TICK: begin
          now_ticks = now_ticks + 1'b1;
        end
        ptq_pkg::OP_POLL: begin
          if (slots.size() > 0 && slots[0].due <= now_ticks) begin
            e            = slots.pop_front();
            r.fired      = 1'b1;
            r.fired_task = e.task_id;
            r.fired_kind = e.kind;
            if (e.kind == ptq_pkg::KIND_RATE) begin
              e.due = e.due + ptq_pkg::TIME_BITS'(e.period);
              file_entry(e);
            end else if (e.kind == ptq_pkg::KIND_DELAY) begin
              e.due = now_ticks + ptq_pkg::TIME_BITS'(e.period);
              file_entry(e);
            end
          end
        end
        default: begin
        end
      endcase
      r.pending_count = 5'(slots.size());
      awaited = {awaited, r};
      return r;
    endfunction

    task compare(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) begin
        report($sformatf("%s got %h want %h", name, got, want));
      end
    endtask

    task check_word(ptq_pkg::out_word_t got);
      ptq_pkg::out_word_t want;
      if (awaited.size() == 0) begin
        report($sformatf("result word %h with nothing outstanding", got));
        return;
      end
      want = awaited.pop_front();
      compare("accepted", 8'(got.accepted), 8'(want.accepted));
      compare("fired", 8'(got.fired), 8'(want.fired));
      compare("fired_task", got.fired_task, want.fired_task);
      compare("fired_kind", 8'(got.fired_kind), 8'(want.fired_kind));
      compare("pending_count", 8'(got.pending_count), 8'(want.pending_count));
    endtask
  endclass

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  ptq_pkg::in_word_t  in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  ptq_pkg::out_word_t out_data;

  timer_queue_scoreboard sb = new();

  int lasting      = 0;
  int results_seen = 0;
  bit sender_calm  = 1'b0;

  periodic_task_timer_queue u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic offer(logic [1:0] op, logic [1:0] kd, logic [7:0] id,
                       logic [23:0] dly, logic [23:0] per);
    ptq_pkg::in_word_t  w;
    ptq_pkg::out_word_t seen;
    int                 gap;
    w.op            = op;
    w.kind          = kd;
    w.task_id       = id;
    w.first_delay   = dly;
    w.repeat_period = per;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    seen = sb.note_word(w);
    // tasks that will sit in the queue for the rest of the run
    if (seen.accepted && (kd != ptq_pkg::KIND_ONCE || dly > 24'd64)) lasting++;
    gap = sender_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin : stimulus
    int          burst_left;
    int          roll;
    logic [1:0]  op;
    logic [1:0]  kd;
    logic [23:0] dly;
    logic [23:0] per;
    burst_left = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    offer(ptq_pkg::OP_POLL, ptq_pkg::KIND_ONCE, 8'h00, 24'h000000, 24'h000000);
    offer(OP_NONE, ptq_pkg::KIND_BAD, 8'hff, 24'hffffff, 24'hffffff);
    offer(ptq_pkg::OP_TICK, ptq_pkg::KIND_ONCE, 8'h00, 24'h000000, 24'h000000);
    offer(ptq_pkg::OP_SCHEDULE, ptq_pkg::KIND_BAD, 8'haa, 24'h000001, 24'h000001);
    offer(ptq_pkg::OP_SCHEDULE, ptq_pkg::KIND_ONCE, 8'h00, 24'h000000, 24'hffffff);
    offer(ptq_pkg::OP_SCHEDULE, ptq_pkg::KIND_ONCE, 8'hff, 24'hffffff, 24'h000000);
    offer(ptq_pkg::OP_SCHEDULE, ptq_pkg::KIND_RATE, 8'h01, 24'h000002, 24'h000003);
    offer(ptq_pkg::OP_SCHEDULE, ptq_pkg::KIND_DELAY, 8'h02, 24'h000002, 24'h000000);
    offer(ptq_pkg::OP_POLL, ptq_pkg::KIND_ONCE, 8'h00, 24'h000000, 24'h000000);
    offer(ptq_pkg::OP_POLL, ptq_pkg::KIND_ONCE, 8'h00, 24'h000000, 24'h000000);
    offer(ptq_pkg::OP_TICK, ptq_pkg::KIND_ONCE, 8'h00, 24'h000000, 24'h000000);
    offer(ptq_pkg::OP_TICK, ptq_pkg::KIND_ONCE, 8'h00, 24'h000000, 24'h000000);
    offer(ptq_pkg::OP_POLL, ptq_pkg::KIND_ONCE, 8'h00, 24'h000000, 24'h000000);
    offer(ptq_pkg::OP_POLL, ptq_pkg::KIND_ONCE, 8'h00, 24'h000000, 24'h000000);
    offer(ptq_pkg::OP_POLL, ptq_pkg::KIND_ONCE, 8'h00, 24'h000000, 24'h000000);
    offer(ptq_pkg::OP_SCHEDULE, ptq_pkg::KIND_ONCE, 8'h03, 24'h000003, 24'h000000);
    offer(ptq_pkg::OP_SCHEDULE, ptq_pkg::KIND_ONCE, 8'h04, 24'h000003, 24'h000000);
    offer(ptq_pkg::OP_TICK, ptq_pkg::KIND_ONCE, 8'h00, 24'h000000, 24'h000000);
    offer(ptq_pkg::OP_TICK, ptq_pkg::KIND_ONCE, 8'h00, 24'h000000, 24'h000000);
    offer(ptq_pkg::OP_TICK, ptq_pkg::KIND_ONCE, 8'h00, 24'h000000, 24'h000000);
    offer(ptq_pkg::OP_POLL, ptq_pkg::KIND_ONCE, 8'h00, 24'h000000, 24'h000000);
    offer(ptq_pkg::OP_POLL, ptq_pkg::KIND_ONCE, 8'h00, 24'h000000, 24'h000000);
    offer(ptq_pkg::OP_POLL, ptq_pkg::KIND_ONCE, 8'h00, 24'h000000, 24'h000000);
    offer(ptq_pkg::OP_POLL, ptq_pkg::KIND_ONCE, 8'h00, 24'h000000, 24'h000000);

    for (int n = 0; n < 1450; n++) begin
      sender_calm = (n % 250) < 50;
      if (n == 700) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.awaited.size() != 0) @(posedge clk);
      end
      if (burst_left == 0 && $urandom_range(99) < 5) burst_left = $urandom_range(12, 6);
      if (burst_left > 0) begin
        burst_left--;
        offer(ptq_pkg::OP_SCHEDULE, ptq_pkg::KIND_ONCE, 8'($urandom),
              24'($urandom_range(8)), 24'($urandom));
      end else begin
        roll = $urandom_range(99);
        op   = roll < 38 ? ptq_pkg::OP_SCHEDULE : roll < 66 ? ptq_pkg::OP_TICK
               : roll < 94 ? ptq_pkg::OP_POLL : OP_NONE;
        kd   = 2'($urandom);
        dly  = 24'($urandom);
        per  = 24'($urandom);
        if (op == ptq_pkg::OP_SCHEDULE) begin
          roll = $urandom_range(99);
          if (lasting < 12) begin
            kd = roll < 80 ? ptq_pkg::KIND_ONCE : roll < 88 ? ptq_pkg::KIND_RATE
                 : roll < 96 ? ptq_pkg::KIND_DELAY : ptq_pkg::KIND_BAD;
          end else begin
            kd = roll < 95 ? ptq_pkg::KIND_ONCE : ptq_pkg::KIND_BAD;
          end
          if (!(kd == ptq_pkg::KIND_ONCE && lasting < 12 && $urandom_range(99) < 3)) begin
            dly = 24'($urandom_range(8));
          end
          if (kd != ptq_pkg::KIND_ONCE && $urandom_range(99) < 85) begin
            per = 24'($urandom_range(6));
          end
        end
        offer(op, kd, 8'($urandom), dly, per);
      end
    end

    in_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : result_sink
    int stall_left;
    int ready_left;
    bit long_hold_done;
    stall_left     = 0;
    ready_left     = 0;
    long_hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        sb.check_word(out_data);
        results_seen++;
      end
      // one long hold so the result word backs up into the input
      if (!long_hold_done && results_seen >= 400) begin
        long_hold_done = 1'b1;
        stall_left     = 300;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (ready_left > 0) begin
          ready_left--;
        end else if ($urandom_range(19) == 0) begin
          ready_left = $urandom_range(60, 20);
        end else begin
          stall_left = pick_gap();
        end
      end
    end
  end

  initial begin : watchdog
    #4000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> sim.f
rtl/ptq_pkg.sv
rtl/ptq_cell.sv
rtl/periodic_task_timer_queue.sv
tb/tb_periodic_task_timer_queue.sv
